[design/erd_pkg.sv]
package erd_pkg;

   localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
   localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

   localparam logic [6:0] NAME_LEN_RESET = 7'd64;
   localparam logic [6:0] NAME_RUN_MAX   = 7'd127;
   localparam logic [7:0] NAME_COUNT_MAX = 8'd255;

   // record length field: event number and type (4 + 1) plus payload; excludes the length field and CRC
   localparam logic [31:0] LEN_HEADER    = 32'd5;
   localparam logic [31:0] LEN_PIXEL     = 32'd14;
   localparam logic [31:0] LEN_ELIM      = 32'd6;
   localparam logic [31:0] LEN_NEW_MIN   = 32'd14;

   // payload byte index limits
   localparam logic [3:0] IDX_MAX        = 4'd15;
   localparam logic [3:0] IDX_WORD_BYTES = 4'd4;
   localparam logic [3:0] IDX_TWO_WORDS  = 4'd8;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CRC     = 2'd1;
   localparam logic [1:0] ST_PAYLOAD = 2'd2;
   localparam logic [1:0] ST_BAD_LEN = 2'd3;

   localparam logic [7:0] KIND_NEW_GAME   = 8'd0;
   localparam logic [7:0] KIND_PIXEL      = 8'd1;
   localparam logic [7:0] KIND_ELIMINATED = 8'd2;
   localparam logic [7:0] KIND_GAME_OVER  = 8'd3;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] event_number;
      logic [1:0]  event_kind;
      logic [7:0]  player_index;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] board_width;
      logic [31:0] board_height;
      logic [7:0]  name_count;
   } erd_result_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] erd_crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[design/event_record_deframer.sv]
// channel | direction | payload
// req_    | in        | tdata: data_byte[7:0]; tlast: datagram_end
// rsp_    | out       | tuser: status, event_kind; tdata: decoded event fields
// csr_    | in        | data: max_name_len[6:0], always ready
//
// One byte per cycle sustained while rsp_ is not stalled; a byte is registered in
// the input register, field decode and CRC-32 update work on the held byte, and
// the result of a record's closing byte lands in the result register (rsp_tvalid).
// Reset clears the parse state, halt flag and both valid flags; max_name_len
// returns to 64. A stalled rsp_ holds its result while the input register still
// takes one more byte, then req_tready drops until the result is taken.
module event_record_deframer
   import erd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,

   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] event_number, [39:32] player_index, [71:40] coord_x, [103:72] coord_y,
   // [135:104] board_width, [167:136] board_height, [175:168] name_count
   output logic [175:0] rsp_tdata,
   output logic [3:0]   rsp_tuser,   // [1:0] status, [3:2] event_kind

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [6:0]   csr_data
);

   logic           in_vld_ff, in_vld_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic [6:0]     name_len_ff;
   logic           rsp_vld_ff, rsp_vld_in;
   erd_result_type rsp_res_ff;

   logic           go;
   logic           res_valid;
   erd_result_type res;

   // advance the held byte when the result register is free or draining
   assign go         = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || go;
   assign csr_ready  = 1'b1;

   erd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .go           (go),
      .data_byte    (in_byte_ff),
      .last         (in_last_ff),
      .max_name_len (name_len_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   always_comb begin
      in_vld_in = req_tvalid ? 1'b1 : (in_vld_ff && !go);
      if (!req_tready) in_vld_in = in_vld_ff;
      rsp_vld_in = rsp_vld_ff && !rsp_tready;
      if (go && res_valid) rsp_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         name_len_ff <= NAME_LEN_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_valid && csr_ready) name_len_ff <= csr_data;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (go && res_valid) rsp_res_ff <= res;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = {rsp_res_ff.event_kind, rsp_res_ff.status};
   assign rsp_tdata  = {rsp_res_ff.name_count, rsp_res_ff.board_height,
                        rsp_res_ff.board_width, rsp_res_ff.coord_y,
                        rsp_res_ff.coord_x, rsp_res_ff.player_index,
                        rsp_res_ff.event_number};

endmodule

[design/erd_parser.sv]
module erd_parser
   import erd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           go,
   input  logic [7:0]     data_byte,
   input  logic           last,
   input  logic [6:0]     max_name_len,
   output logic           res_valid,
   output erd_result_type res
);

   typedef enum logic [2:0] {
      PH_LEN,
      PH_EVNO,
      PH_TYPE,
      PH_PAYLOAD,
      PH_CRC,
      PH_BADLEN
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [3:0]  idx_ff, idx_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] evno_ff, evno_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rcv_ff, rcv_in;
   logic [31:0] word0_ff, word0_in;
   logic [31:0] word1_ff, word1_in;
   logic [7:0]  player_ff, player_in;
   logic [6:0]  run_ff, run_in;
   logic [7:0]  names_ff, names_in;
   logic        zero_ff, zero_in;
   logic        invalid_ff, invalid_in;
   logic        halted_ff, halted_in;
   logic        ge9_ff, ge9_in;
   logic        eq9_ff, eq9_in;
   logic        eq1_ff, eq1_in;
   logic        eq0_ff, eq0_in;

   logic [31:0] crc_next;
   logic [31:0] rcv_next;
   logic [6:0]  run_inc;
   logic        restart;
   logic        payload_ok;

   always_comb begin
      crc_next   = erd_crc_byte(crc_ff, data_byte);
      rcv_next   = {rcv_ff[23:0], data_byte};
      run_inc    = (run_ff < NAME_RUN_MAX) ? run_ff + 7'd1 : run_ff;
      restart    = 1'b0;
      res_valid  = 1'b0;
      res        = '0;

      phase_in   = phase_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      len_in     = len_ff;
      evno_in    = evno_ff;
      type_in    = type_ff;
      crc_in     = crc_ff;
      rcv_in     = rcv_ff;
      word0_in   = word0_ff;
      word1_in   = word1_ff;
      player_in  = player_ff;
      run_in     = run_ff;
      names_in   = names_ff;
      zero_in    = zero_ff;
      invalid_in = invalid_ff;
      halted_in  = halted_ff;
      ge9_in     = ge9_ff;
      eq9_in     = eq9_ff;
      eq1_in     = eq1_ff;
      eq0_in     = eq0_ff;

      case (type_ff)
         KIND_NEW_GAME:   payload_ok = ge9_ff && zero_ff && !invalid_ff;
         KIND_PIXEL:      payload_ok = eq9_ff;
         KIND_ELIMINATED: payload_ok = eq1_ff;
         default:         payload_ok = eq0_ff;
      endcase

      if (go && !halted_ff) begin
         case (phase_ff)
            PH_LEN: begin
               crc_in = crc_next;
               len_in = {len_ff[23:0], data_byte};
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) phase_in = PH_EVNO;
            end
            PH_EVNO: begin
               crc_in  = crc_next;
               evno_in = {evno_ff[23:0], data_byte};
               cnt_in  = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) phase_in = PH_TYPE;
            end
            PH_TYPE: begin
               crc_in  = crc_next;
               type_in = data_byte;
               cnt_in  = 2'd0;
               idx_in  = 4'd0;
               rem_in  = len_ff - LEN_HEADER;
               ge9_in  = len_ff >= LEN_NEW_MIN;
               eq9_in  = len_ff == LEN_PIXEL;
               eq1_in  = len_ff == LEN_ELIM;
               eq0_in  = len_ff == LEN_HEADER;
               if (len_ff < LEN_HEADER)       phase_in = PH_BADLEN;
               else if (len_ff == LEN_HEADER) phase_in = PH_CRC;
               else                           phase_in = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               crc_in  = crc_next;
               zero_in = data_byte == 8'd0;
               if (type_ff == KIND_PIXEL || type_ff == KIND_ELIMINATED) begin
                  if (idx_ff == 4'd0) begin
                     player_in = data_byte;
                  end else if (idx_ff <= IDX_WORD_BYTES) begin
                     word0_in = {word0_ff[23:0], data_byte};
                  end else if (idx_ff <= IDX_TWO_WORDS) begin
                     word1_in = {word1_ff[23:0], data_byte};
                  end
               end else if (type_ff == KIND_NEW_GAME) begin
                  if (idx_ff < IDX_WORD_BYTES) begin
                     word0_in = {word0_ff[23:0], data_byte};
                  end else if (idx_ff < IDX_TWO_WORDS) begin
                     word1_in = {word1_ff[23:0], data_byte};
                  end else if (data_byte == 8'd0) begin
                     // name terminator: an empty name is a payload error
                     if (run_ff == 7'd0) invalid_in = 1'b1;
                     else if (names_ff < NAME_COUNT_MAX) names_in = names_ff + 8'd1;
                     run_in = 7'd0;
                  end else begin
                     run_in = run_inc;
                     if (run_inc > max_name_len) invalid_in = 1'b1;
                  end
               end
               idx_in = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + 4'd1;
               rem_in = rem_ff - 32'd1;
               if (rem_ff == 32'd1) phase_in = PH_CRC;
            end
            PH_CRC: begin
               rcv_in = rcv_next;
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  restart = 1'b1;
                  if (~crc_ff != rcv_next) begin
                     res_valid        = 1'b1;
                     res.status       = ST_CRC;
                     res.event_number = evno_ff;
                     halted_in        = 1'b1;
                  end else if (type_ff <= KIND_GAME_OVER) begin
                     res_valid        = 1'b1;
                     res.event_number = evno_ff;
                     if (!payload_ok) begin
                        res.status = ST_PAYLOAD;
                        halted_in  = 1'b1;
                     end else begin
                        res.status     = ST_OK;
                        res.event_kind = type_ff[1:0];
                        if (type_ff == KIND_PIXEL || type_ff == KIND_ELIMINATED)
                           res.player_index = player_ff;
                        if (type_ff == KIND_PIXEL) begin
                           res.coord_x = word0_ff;
                           res.coord_y = word1_ff;
                        end
                        if (type_ff == KIND_NEW_GAME) begin
                           res.board_width  = word0_ff;
                           res.board_height = word1_ff;
                           res.name_count   = names_ff;
                        end
                     end
                  end
               end
            end
            PH_BADLEN: begin
               cnt_in = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  restart          = 1'b1;
                  res_valid        = 1'b1;
                  res.status       = ST_BAD_LEN;
                  res.event_number = evno_ff;
                  halted_in        = 1'b1;
               end
            end
            default: begin
               restart = 1'b1;
            end
         endcase
      end

      // end of datagram: drop any partial record and resume parsing
      if (go && last) begin
         restart   = 1'b1;
         halted_in = 1'b0;
      end

      if (restart) begin
         phase_in   = PH_LEN;
         cnt_in     = 2'd0;
         idx_in     = 4'd0;
         crc_in     = CRC_PRESET;
         run_in     = 7'd0;
         names_in   = 8'd0;
         zero_in    = 1'b0;
         invalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN;
         cnt_ff     <= 2'd0;
         idx_ff     <= 4'd0;
         crc_ff     <= CRC_PRESET;
         run_ff     <= 7'd0;
         names_ff   <= 8'd0;
         zero_ff    <= 1'b0;
         invalid_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         crc_ff     <= crc_in;
         run_ff     <= run_in;
         names_ff   <= names_in;
         zero_ff    <= zero_in;
         invalid_ff <= invalid_in;
         halted_ff  <= halted_in;
      end
      rem_ff    <= rem_in;
      len_ff    <= len_in;
      evno_ff   <= evno_in;
      type_ff   <= type_in;
      rcv_ff    <= rcv_in;
      word0_ff  <= word0_in;
      word1_ff  <= word1_in;
      player_ff <= player_in;
      ge9_ff    <= ge9_in;
      eq9_ff    <= eq9_in;
      eq1_ff    <= eq1_in;
      eq0_ff    <= eq0_in;
   end

   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_valid)
      else $error("result produced while datagram halted");

   a_error_halts: assert property (@(posedge clock) disable iff (reset)
      go && res_valid && res.status != ST_OK && !last |=> halted_ff)
      else $error("error result did not halt the datagram");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      go && last |=> phase_ff == PH_LEN && !halted_ff && cnt_ff == 2'd0)
      else $error("datagram end did not restart parsing");

   a_event_from_crc: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == ST_OK |-> phase_ff == PH_CRC && cnt_ff == 2'd3)
      else $error("event emitted outside the CRC field");

endmodule
